FILE: hw/rtl/psg_pkg.sv
// Shared types and constants for the pre-trade signal guard.
`timescale 1ns / 1ps
`default_nettype none
package psg_pkg;

  // field widths
  localparam int MODE_W   = 2;
  localparam int VENUE_W  = 3;
  localparam int TICK_W   = 32;
  localparam int TIME_W   = 63;
  localparam int QTY_W    = 32;
  localparam int PRICE_W  = 32;
  localparam int LIMIT_W  = 47;
  localparam int NOTION_W = 64;
  localparam int FRAC_W   = 16;
  localparam int ACTION_W = 2;
  localparam int VERDICT_W = 3;

  // every code a venue field can carry
  localparam int VENUE_CODES = 1 << VENUE_W;

  // input word packing, lowest bit first
  localparam int IN_FIELDS_W = 2 * VENUE_W + TICK_W + TIME_W + QTY_W + PRICE_W;
  localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((VERDICT_W + 7) / 8) * 8;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 63;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_ORDER = 2'd0,
    CFG_POS_LIMIT = 2'd1,
    CFG_COOLDOWN  = 2'd2,
    CFG_SPARE     = 2'd3
  } cfg_idx_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_SIGNAL = 2'd0,
    MODE_FILL   = 2'd1,
    MODE_PAUSE  = 2'd2,
    MODE_RESUME = 2'd3
  } mode_t;

  typedef enum logic [ACTION_W-1:0] {
    ACT_NONE     = 2'd0,
    ACT_DISPATCH = 2'd1,
    ACT_PAUSE    = 2'd2,
    ACT_RESUME   = 2'd3
  } action_t;

  typedef enum logic [VERDICT_W-1:0] {
    VER_PASSED     = 3'd0,
    VER_PRICE      = 3'd1,
    VER_POSITION   = 3'd2,
    VER_PAUSED     = 3'd3,
    VER_COOLDOWN   = 3'd4,
    VER_NOT_SIGNAL = 3'd5
  } verdict_t;

endpackage
`default_nettype wire

FILE: hw/rtl/pretrade_signal_guard.sv
// Pre-trade signal guard: limit, kill switch and per-pair cooldown gate.
`timescale 1ns / 1ps
`default_nettype none
// Channel   Dir  Handshake              Carries
// s_axis    in   tvalid/tready          tuser mode, tdata signal and fill fields
// m_axis    out  tvalid/tready          tuser action, tdata verdict
// cfg       in   cfg_valid/cfg_ready    cfg_index, cfg_data
//
// One item per cycle while the output is taken; the result is registered in the output word.
// The accept cycle reads the pair time memory and registers qty * price; the
// evaluation stage then runs the checks, updates the accumulator and writes the memory.
// A write and a read of the same pair in one cycle are resolved by forwarding.
// A stalled output word holds the evaluation stage, which holds the input.
// Reset clears limits, accumulator, kill switch and pair valid bits at once.
module pretrade_signal_guard #(
  parameter int NUM_VENUES = 8
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // from bit 0: sell venue, buy venue, sell bid in cents, detection time,
  // fill quantity, fill price, zero fill
  input  wire logic [psg_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // mode
  input  wire logic [psg_pkg::MODE_W-1:0]      s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // from bit 0: verdict, zero fill
  output logic [psg_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
  // action
  output logic [psg_pkg::ACTION_W-1:0]         m_axis_tuser,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [psg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [psg_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import psg_pkg::*;

  localparam int VIDX_W = (NUM_VENUES > 1) ? $clog2(NUM_VENUES) : 1;
  localparam int NPAIRS = NUM_VENUES * NUM_VENUES;
  localparam int PAIR_W = $clog2(NPAIRS);

  localparam int SV_LO  = 0;
  localparam int BV_LO  = SV_LO + VENUE_W;
  localparam int TK_LO  = BV_LO + VENUE_W;
  localparam int TM_LO  = TK_LO + TICK_W;
  localparam int QT_LO  = TM_LO + TIME_W;
  localparam int PR_LO  = QT_LO + QTY_W;

  // input field split
  logic [VENUE_W-1:0] in_sell;
  logic [VENUE_W-1:0] in_buy;
  logic [TICK_W-1:0]  in_tick;
  logic [TIME_W-1:0]  in_time;
  logic [QTY_W-1:0]   in_qty;
  logic [PRICE_W-1:0] in_price;

  assign in_sell  = s_axis_tdata[SV_LO +: VENUE_W];
  assign in_buy   = s_axis_tdata[BV_LO +: VENUE_W];
  assign in_tick  = s_axis_tdata[TK_LO +: TICK_W];
  assign in_time  = s_axis_tdata[TM_LO +: TIME_W];
  assign in_qty   = s_axis_tdata[QT_LO +: QTY_W];
  assign in_price = s_axis_tdata[PR_LO +: PRICE_W];

  // venue code reduced modulo the venue count, worked out at elaboration
  logic [VIDX_W-1:0] venue_mod [VENUE_CODES];
  for (genvar g = 0; g < VENUE_CODES; g++) begin : g_mod
    localparam int MODV = g % NUM_VENUES;
    assign venue_mod[g] = VIDX_W'(MODV);
  end

  logic [PAIR_W-1:0] in_pair;
  assign in_pair = PAIR_W'(PAIR_W'(venue_mod[in_sell]) * PAIR_W'(NUM_VENUES))
                 + PAIR_W'(venue_mod[in_buy]);

  // configuration
  logic [TICK_W-1:0]  max_order;
  logic [LIMIT_W-1:0] pos_limit;
  logic [TIME_W-1:0]  cooldown;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_order <= '0;
      pos_limit <= '0;
      cooldown  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_MAX_ORDER: max_order <= cfg_data[TICK_W-1:0];
        CFG_POS_LIMIT: pos_limit <= cfg_data[LIMIT_W-1:0];
        CFG_COOLDOWN:  cooldown  <= cfg_data[TIME_W-1:0];
        default: ;
      endcase
    end
  end

  // handshake
  logic busy;
  logic exec_done;
  logic in_acc;

  assign exec_done     = busy && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !busy || exec_done;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (in_acc) begin
      busy <= 1'b1;
    end else if (exec_done) begin
      busy <= 1'b0;
    end
  end

  // item registers, loaded on accept
  mode_t                mode_q;
  logic [TICK_W-1:0]    tick_q;
  logic [TIME_W-1:0]    time_q;
  logic [PAIR_W-1:0]    pair_q;
  logic [NOTION_W-1:0]  prod_q;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      mode_q <= mode_t'(s_axis_tuser);
      tick_q <= in_tick;
      time_q <= in_time;
      pair_q <= in_pair;
      prod_q <= NOTION_W'(in_qty) * NOTION_W'(in_price);
    end
  end

  // pair time memory, one read port and one write port
  logic [TIME_W-1:0] pair_mem [NPAIRS];
  logic [TIME_W-1:0] mem_rdata;
  logic              mem_we;
  logic              fwd_hit;
  logic [TIME_W-1:0] fwd_data;
  logic [TIME_W-1:0] last_time;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      pair_mem[pair_q] <= time_q;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      mem_rdata <= pair_mem[in_pair];
    end
  end

  // a write landing in the read cycle of the same pair wins over the old data
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_hit <= 1'b0;
    end else if (in_acc) begin
      fwd_hit <= mem_we && (pair_q == in_pair);
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      fwd_data <= time_q;
    end
  end

  assign last_time = fwd_hit ? fwd_data : mem_rdata;

  // pair valid bits
  logic [NPAIRS-1:0] pair_seen;

  always_ff @(posedge clk) begin
    if (rst) begin
      pair_seen <= '0;
    end else if (mem_we) begin
      pair_seen[pair_q] <= 1'b1;
    end
  end

  // accumulator and kill switch
  logic [NOTION_W-1:0] open_notional;
  logic [NOTION_W-1:0] open_notional_next;
  logic                kill_switch;
  logic                kill_switch_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      open_notional <= '0;
      kill_switch   <= 1'b0;
    end else if (exec_done) begin
      open_notional <= open_notional_next;
      kill_switch   <= kill_switch_next;
    end
  end

  // checks
  logic [NOTION_W:0] pos_sum;
  logic [NOTION_W:0] pos_cap;
  logic [NOTION_W:0] fill_sum;
  logic [TIME_W:0]   gap;
  logic              price_over;
  logic              pos_over;
  logic              cool_fail;
  action_t           action;
  verdict_t          verdict;

  assign pos_sum  = {1'b0, open_notional} + (NOTION_W + 1)'({tick_q, {FRAC_W{1'b0}}});
  assign pos_cap  = (NOTION_W + 1)'({pos_limit, {FRAC_W{1'b0}}});
  assign fill_sum = {1'b0, open_notional} + {1'b0, prod_q};
  // a negative gap means an earlier timestamp and fails the cooldown check once the pair has been seen
  assign gap      = {1'b0, time_q} - {1'b0, last_time};

  assign price_over = (max_order != '0) && (tick_q > max_order);
  assign pos_over   = (pos_limit != '0) && (pos_sum > pos_cap);
  assign cool_fail  = pair_seen[pair_q] && (gap[TIME_W] || (gap[TIME_W-1:0] < cooldown));

  always_comb begin
    action             = ACT_NONE;
    verdict            = VER_NOT_SIGNAL;
    mem_we             = 1'b0;
    open_notional_next = open_notional;
    kill_switch_next   = kill_switch;
    unique case (mode_q)
      MODE_SIGNAL: begin
        if (price_over) begin
          verdict = VER_PRICE;
        end else if (pos_over) begin
          verdict = VER_POSITION;
        end else if (kill_switch) begin
          verdict = VER_PAUSED;
        end else if ((cooldown != '0) && cool_fail) begin
          verdict = VER_COOLDOWN;
        end else begin
          verdict = VER_PASSED;
          action  = ACT_DISPATCH;
          mem_we  = exec_done && (cooldown != '0);
        end
      end
      MODE_FILL: begin
        open_notional_next = fill_sum[NOTION_W] ? '1 : fill_sum[NOTION_W-1:0];
      end
      MODE_PAUSE: begin
        kill_switch_next = 1'b1;
        action           = ACT_PAUSE;
      end
      MODE_RESUME: begin
        kill_switch_next = 1'b0;
        action           = ACT_RESUME;
      end
      default: ;
    endcase
  end

  // output word register
  action_t  out_action;
  verdict_t out_verdict;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (exec_done) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_done) begin
      out_action  <= action;
      out_verdict <= verdict;
    end
  end

  assign m_axis_tuser = out_action;
  assign m_axis_tdata = OUT_TDATA_W'(out_verdict);

endmodule
`default_nettype wire
